// ===== design/vos_pkg.sv =====
// Shared constants, types and helper functions of the obstacle steering block.
`default_nettype none
package vos_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    localparam int XY_W   = 38;
    localparam int Z_W    = 21;
    localparam int ANG_W  = 17;
    localparam int CNT_W  = 5;

    localparam logic signed [ANG_W-1:0] PI_Q13      = 17'sd25736;
    localparam logic signed [17:0]      TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [Z_W-1:0]   PI_Q16      = 21'sd205887;
    localparam logic signed [Z_W-1:0]   HALF_PI_Q16 = 21'sd102944;
    localparam logic [15:0]             CORDIC_GAIN = 16'd39797;
    localparam logic [15:0]             MAG_SCALE   = 16'd1000;
    // Shift of the folded angle when the 24-bit beam angle wraps (2pi minus 2^24 mod 2pi).
    localparam logic signed [17:0]      WRAP_ADJ    = 18'sd2656;

    localparam logic [2:0] REG_ATT_GAIN  = 3'd0;
    localparam logic [2:0] REG_REP_GAIN  = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_MAX_LIN   = 3'd3;
    localparam logic [2:0] REG_MAX_ANG   = 3'd4;
    localparam logic [2:0] REG_ANG_START = 3'd5;
    localparam logic [2:0] REG_ANG_STEP  = 3'd6;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_MAG,
        OP_DIV_LOAD_MAG,
        OP_DIV_STEP,
        OP_MUL_ROT,
        OP_ROT_LOAD,
        OP_ROT_STEP,
        OP_MUL_LIN,
        OP_DIV_LOAD_LIN,
        OP_VEC_LOAD,
        OP_VEC_STEP,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic rep_active;
    } dp_stat_t;

    // Arctangent of 2^-i in Q16 radians.
    function automatic logic [16:0] atan_q16(input logic [CNT_W-1:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Fold an angle within one turn of [-pi, pi) back into [-pi, pi).
    function automatic logic signed [ANG_W-1:0] wrap_once(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a >= 18'sd25736) begin
            r = a - TWO_PI_Q13;
        end else if (a < -18'sd25736) begin
            r = a + TWO_PI_Q13;
        end
        return r[ANG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/vff_obstacle_steering.sv =====
// Top level of the virtual force field obstacle steering block.
`default_nettype none
// Usage:
//   The slave stream carries one lidar beam per word: tdata holds the range
//   in millimeters, tuser flags a finite reading and tlast marks the final
//   beam of a scan. Beams are taken one per cycle while a scan runs; the
//   beam angle starts at the angle_start register and advances by angle_step.
//   The last beam of a scan produces one master word: tdata holds linear
//   speed (low half) and angular speed (high half), tuser the obstacle flag.
//   After the last beam, s_tready stays low for the command computation:
//   two restoring divides plus two CORDIC passes of CORDIC_STEPS iterations
//   with an obstacle at nonzero distance, one divide and one CORDIC pass
//   without one. The shared divider and the single CORDIC unit run these
//   steps one after another. A new scan may start while the result word still
//   waits in the output register; a following result waits until m_tready
//   frees that register. Registers load through cfg_wr_en/cfg_addr/cfg_wdata.
//   Synchronous active-low reset restores register defaults, rearms the scan
//   and empties the output register.
module vff_obstacle_steering (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] range_mm
    input  wire logic        s_tuser,   // [0] range_finite
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] lin_speed, [31:16] turn_rate
    output logic             m_tuser    // [0] obs_flag
);
    import vos_pkg::*;

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        in_fire;
    logic [15:0] lin, ang;

    assign in_fire = s_tvalid && s_tready;

    vos_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    vos_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_fire      (in_fire),
        .range_mm     (s_tdata),
        .range_finite (s_tuser),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .lin_speed    (lin),
        .turn_rate    (ang),
        .obs_flag     (m_tuser)
    );

    assign m_tdata = {ang, lin};

endmodule
`default_nettype wire

// ===== design/vos_ctrl.sv =====
// Sequencer of the end-of-scan command computation.
`default_nettype none
module vos_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            in_last,
    output logic                 in_ready,
    input  wire logic            out_ready,
    output logic                 out_valid,
    input  wire vos_pkg::dp_stat_t stat,
    output vos_pkg::dp_cmd_t     cmd
);
    import vos_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MUL_MAG  = 13'b0000000000010,
        S_DIVL_MAG = 13'b0000000000100,
        S_DIV_MAG  = 13'b0000000001000,
        S_MUL_ROT  = 13'b0000000010000,
        S_ROT_LOAD = 13'b0000000100000,
        S_ROT      = 13'b0000001000000,
        S_MUL_LIN  = 13'b0000010000000,
        S_DIVL_LIN = 13'b0000100000000,
        S_DIV_LIN  = 13'b0001000000000,
        S_VEC_LOAD = 13'b0010000000000,
        S_VEC      = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             div_done, cor_done, in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign div_done  = (cnt_reg == {CNT_W{1'b1}});
    assign cor_done  = (cnt_reg == CNT_W'(CORDIC_ITERS - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        cmd.op     = OP_NOP;
        cmd.idx    = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && in_last) begin
                    state_next = S_MUL_MAG;
                end
            end
            S_MUL_MAG: begin
                cmd.op     = OP_MUL_MAG;
                state_next = stat.rep_active ? S_DIVL_MAG : S_MUL_LIN;
            end
            S_DIVL_MAG: begin
                cmd.op     = OP_DIV_LOAD_MAG;
                cnt_next   = '0;
                state_next = S_DIV_MAG;
            end
            S_DIV_MAG: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (div_done) begin
                    state_next = S_MUL_ROT;
                end
            end
            S_MUL_ROT: begin
                cmd.op     = OP_MUL_ROT;
                state_next = S_ROT_LOAD;
            end
            S_ROT_LOAD: begin
                cmd.op     = OP_ROT_LOAD;
                cnt_next   = '0;
                state_next = S_ROT;
            end
            S_ROT: begin
                cmd.op   = OP_ROT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cor_done) begin
                    state_next = S_MUL_LIN;
                end
            end
            S_MUL_LIN: begin
                cmd.op     = OP_MUL_LIN;
                state_next = S_DIVL_LIN;
            end
            S_DIVL_LIN: begin
                cmd.op     = OP_DIV_LOAD_LIN;
                cnt_next   = '0;
                state_next = S_DIV_LIN;
            end
            S_DIV_LIN: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (div_done) begin
                    state_next = S_VEC_LOAD;
                end
            end
            S_VEC_LOAD: begin
                cmd.op     = OP_VEC_LOAD;
                cnt_next   = '0;
                state_next = S_VEC;
            end
            S_VEC: begin
                cmd.op   = OP_VEC_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cor_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output word slot is free
                if (!valid_reg || out_ready) begin
                    cmd.op     = OP_WRITE;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last) |=> !in_ready)
        else $error("input taken right after a last sample");
    a_write_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_WRITE) |-> (!valid_reg || out_ready))
        else $error("result overwrote an undelivered word");
    a_rot_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROT_LOAD) |=> (cnt_reg == '0))
        else $error("rotation did not start at step zero");
    a_vec_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VEC_LOAD) |=> (cnt_reg == '0))
        else $error("vectoring did not start at step zero");

endmodule
`default_nettype wire

// ===== design/vos_dpath.sv =====
// Scan tracking, configuration registers, divider, multiplier and CORDIC datapath.
`default_nettype none
module vos_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_addr,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              in_fire,
    input  wire logic [15:0]       range_mm,
    input  wire logic              range_finite,
    input  wire logic              in_last,
    input  wire vos_pkg::dp_cmd_t  cmd,
    output vos_pkg::dp_stat_t      stat,
    output logic [15:0]            lin_speed,
    output logic [15:0]            turn_rate,
    output logic                   obs_flag
);
    import vos_pkg::*;

    // configuration
    logic [15:0] att_gain_reg, rep_gain_reg, thr_reg, max_lin_reg, ang_start_reg;
    logic [14:0] max_ang_reg, ang_step_reg;

    // scan tracking
    logic [15:0]             near_range_reg;
    logic signed [ANG_W-1:0] near_angle_reg, wrap_reg;
    logic                    found_reg, started_reg;
    logic [23:0]             beam_reg;

    // snapshot of the finished scan
    logic [15:0]             snap_range_reg;
    logic signed [ANG_W-1:0] snap_angle_reg;
    logic                    snap_found_reg;

    // arithmetic
    logic [31:0]            prod_reg, div_q_reg;
    logic [15:0]            div_rem_reg, div_d_reg, lin_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic                   flip_reg, zero_reg;
    logic [15:0]            lin_out_reg, ang_out_reg;
    logic                   found_out_reg;

    logic        start_wr, rearm_cfg, hit;
    logic [15:0] rearm_src;
    logic [23:0] rearm_beam, step24, beam_next;
    logic signed [ANG_W-1:0] rearm_wrap, wrap_next;
    logic signed [24:0] sum25;
    logic signed [17:0] adj, wsum;
    logic [15:0] mul_a, mul_b, mag_sat;
    logic [16:0] div_rs;
    logic        div_ge;
    logic signed [Z_W-1:0]  z_init, at;
    logic signed [XY_W-1:0] xs, ys, px, py, rx, ry, ag_ext;
    logic        pos, rep;
    logic signed [Z_W-1:0]  zr;
    logic signed [17:0]     w, mx;

    assign start_wr  = cfg_wr_en && (cfg_addr == REG_ANG_START);
    assign rearm_cfg = start_wr && !started_reg;
    assign rearm_src = rearm_cfg ? cfg_wdata : ang_start_reg;
    assign rearm_beam = {{8{rearm_src[15]}}, rearm_src};
    assign rearm_wrap = wrap_once({{2{rearm_src[15]}}, rearm_src});

    assign hit = range_finite && (range_mm < thr_reg) && (range_mm < near_range_reg);

    // advance the beam angle and its folded copy together
    assign step24 = {{9{ang_step_reg[14]}}, ang_step_reg};
    assign sum25  = $signed({beam_reg[23], beam_reg}) + $signed({step24[23], step24});
    assign beam_next = sum25[23:0];
    always_comb begin
        adj = {{3{ang_step_reg[14]}}, ang_step_reg};
        if (!sum25[24] && sum25[23]) begin
            adj = adj + WRAP_ADJ;
        end else if (sum25[24] && !sum25[23]) begin
            adj = adj - WRAP_ADJ;
        end
    end
    assign wsum      = {wrap_reg[ANG_W-1], wrap_reg} + adj;
    assign wrap_next = wrap_once(wsum);

    assign rep = snap_found_reg && (snap_range_reg != 16'd0);
    assign stat.rep_active = rep;

    assign mag_sat = (div_q_reg[31:16] != 16'd0) ? 16'hFFFF : div_q_reg[15:0];

    always_comb begin
        case (cmd.op)
            OP_MUL_MAG: begin
                mul_a = rep_gain_reg;
                mul_b = MAG_SCALE;
            end
            OP_MUL_ROT: begin
                mul_a = mag_sat;
                mul_b = CORDIC_GAIN;
            end
            default: begin
                mul_a = max_lin_reg;
                mul_b = snap_range_reg;
            end
        endcase
    end

    assign div_rs = {div_rem_reg, div_q_reg[31]};
    assign div_ge = (div_rs >= {1'b0, div_d_reg});

    always_comb begin
        z_init = $signed({{(Z_W-ANG_W-3){snap_angle_reg[ANG_W-1]}}, snap_angle_reg, 3'b000});
    end

    assign at = $signed({{(Z_W-17){1'b0}}, atan_q16(cmd.idx)});
    assign xs = x_reg >>> cmd.idx;
    assign ys = y_reg >>> cmd.idx;
    assign pos = (cmd.op == OP_VEC_STEP) ? y_reg[XY_W-1] : !z_reg[Z_W-1];

    assign px = flip_reg ? -x_reg : x_reg;
    assign py = flip_reg ? -y_reg : y_reg;
    assign ag_ext = $signed({{(XY_W-32){1'b0}}, att_gain_reg, 16'd0});
    assign rx = rep ? (ag_ext - px) : ag_ext;
    assign ry = rep ? -py : '0;

    assign zr = (z_reg + 21'sd4) >>> 3;
    assign w  = zr[17:0];
    assign mx = {3'b000, max_ang_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_gain_reg   <= 16'd4096;
            rep_gain_reg   <= 16'd6144;
            thr_reg        <= 16'd1500;
            max_lin_reg    <= 16'd2048;
            max_ang_reg    <= 15'd8192;
            ang_start_reg  <= 16'h9B78;
            ang_step_reg   <= 15'd143;
            near_range_reg <= 16'hFFFF;
            near_angle_reg <= '0;
            found_reg      <= 1'b0;
            started_reg    <= 1'b0;
            beam_reg       <= 24'hFF9B78;
            wrap_reg       <= -PI_Q13;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ATT_GAIN:  att_gain_reg  <= cfg_wdata;
                    REG_REP_GAIN:  rep_gain_reg  <= cfg_wdata;
                    REG_THRESHOLD: thr_reg       <= cfg_wdata;
                    REG_MAX_LIN:   max_lin_reg   <= cfg_wdata;
                    REG_MAX_ANG:   max_ang_reg   <= cfg_wdata[14:0];
                    REG_ANG_START: ang_start_reg <= cfg_wdata;
                    REG_ANG_STEP:  ang_step_reg  <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (in_fire && in_last) begin
                near_range_reg <= 16'hFFFF;
                near_angle_reg <= '0;
                found_reg      <= 1'b0;
                started_reg    <= 1'b0;
                beam_reg       <= rearm_beam;
                wrap_reg       <= rearm_wrap;
            end else if (in_fire) begin
                started_reg <= 1'b1;
                beam_reg    <= beam_next;
                wrap_reg    <= wrap_next;
                if (hit) begin
                    near_range_reg <= range_mm;
                    near_angle_reg <= wrap_reg;
                    found_reg      <= 1'b1;
                end
            end else if (rearm_cfg) begin
                beam_reg <= rearm_beam;
                wrap_reg <= rearm_wrap;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_last) begin
            snap_range_reg <= hit ? range_mm : near_range_reg;
            snap_angle_reg <= hit ? wrap_reg : near_angle_reg;
            snap_found_reg <= hit || found_reg;
        end
        case (cmd.op)
            OP_MUL_MAG, OP_MUL_ROT, OP_MUL_LIN: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_DIV_LOAD_MAG: begin
                div_rem_reg <= '0;
                div_q_reg   <= prod_reg;
                div_d_reg   <= snap_range_reg;
            end
            OP_DIV_LOAD_LIN: begin
                div_rem_reg <= '0;
                div_q_reg   <= prod_reg;
                div_d_reg   <= thr_reg;
            end
            OP_DIV_STEP: begin
                div_rem_reg <= div_ge ? 16'(div_rs - {1'b0, div_d_reg}) : div_rs[15:0];
                div_q_reg   <= {div_q_reg[30:0], div_ge};
            end
            OP_ROT_LOAD: begin
                x_reg <= $signed({{(XY_W-32){1'b0}}, prod_reg});
                y_reg <= '0;
                if (z_init > HALF_PI_Q16) begin
                    z_reg    <= z_init - PI_Q16;
                    flip_reg <= 1'b1;
                end else if (z_init < -HALF_PI_Q16) begin
                    z_reg    <= z_init + PI_Q16;
                    flip_reg <= 1'b1;
                end else begin
                    z_reg    <= z_init;
                    flip_reg <= 1'b0;
                end
            end
            OP_ROT_STEP, OP_VEC_STEP: begin
                if (pos) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            OP_VEC_LOAD: begin
                lin_reg  <= snap_found_reg ? div_q_reg[15:0] : max_lin_reg;
                zero_reg <= (rx == '0) && (ry == '0);
                if (rx < 0) begin
                    z_reg <= ry[XY_W-1] ? -PI_Q16 : PI_Q16;
                    x_reg <= -rx;
                    y_reg <= -ry;
                end else begin
                    z_reg <= '0;
                    x_reg <= rx;
                    y_reg <= ry;
                end
            end
            OP_WRITE: begin
                lin_out_reg   <= lin_reg;
                found_out_reg <= snap_found_reg;
                if (zero_reg) begin
                    ang_out_reg <= '0;
                end else if (w > mx) begin
                    ang_out_reg <= mx[15:0];
                end else if (w < -mx) begin
                    ang_out_reg <= 16'(-mx);
                end else begin
                    ang_out_reg <= w[15:0];
                end
            end
            default: ;
        endcase
    end

    assign lin_speed = lin_out_reg;
    assign turn_rate = ang_out_reg;
    assign obs_flag  = found_out_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench of vff_obstacle_steering: directed scans, then random scans under config phases.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vos_pkg::*;

    localparam longint ATAN_TBL [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    localparam longint PI16   = 205887;
    localparam longint HPI16  = 102944;
    localparam longint GAIN16 = 39797;
    localparam int     STALL_BUDGET = 130;

    typedef struct {
        logic [15:0] lin;
        logic [15:0] ang;
        logic        found;
    } steer_cmd_t;

    // One row of the directed table; typed rows carry the speed and flag to expect.
    typedef struct {
        logic [15:0] range_mm;
        logic        finite;
        logic        last;
        bit          typed;
        logic [15:0] lin;
        logic        found;
    } beam_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Shadow registers and scan state of the steering predictor.
    int          att_gain, rep_gain, dist_thr, max_lin, max_ang;
    logic [15:0] ang_start;
    logic [14:0] ang_step;
    int          near_rng, near_ang;
    bit          found_q;
    logic [23:0] beam_q;

    steer_cmd_t  cmd_q[$];
    int          mismatches = 0;
    bit          quiet = 0;
    int          stall_left = 0;

    always #5 aclk = ~aclk;

    vff_obstacle_steering i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic void rearm_scan();
        near_rng = 16'hFFFF;
        near_ang = 0;
        found_q  = 1'b0;
        beam_q   = {{8{ang_start[15]}}, ang_start};
    endfunction

    // Fold the 24-bit beam angle into [-pi, pi).
    function automatic int fold_angle(logic [23:0] a);
        longint v;
        v = longint'($signed(a)) + 25736;
        v = v % 51472;
        if (v < 0) v += 51472;
        return int'(v - 25736);
    endfunction

    // Rotate (mag, 0) by z (Q16 radians).
    task automatic rotate_vec(input longint mag, input longint z,
                              output longint ox, output longint oy);
        longint x, y, t;
        bit flip;
        x = mag; y = 0; flip = 0;
        if (z > HPI16) begin
            z -= PI16; flip = 1;
        end else if (z < -HPI16) begin
            z += PI16; flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TBL[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TBL[i];
            end
        end
        ox = flip ? -x : x;
        oy = flip ? -y : y;
    endtask

    // Heading of (x, y) in Q16 radians.
    function automatic longint heading_of(longint x, longint y);
        longint z, t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI16 : -PI16;
            x = -x; y = -y;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (y < 0) begin
                t = x - (y >>> i); y = y + (x >>> i); x = t; z -= ATAN_TBL[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); x = t; z += ATAN_TBL[i];
            end
        end
        return z;
    endfunction

    // Advance the scan by one beam; on the last beam return the steering command.
    task automatic track_beam(input logic [15:0] r, input logic fin, input logic lst,
                              output bit done, output steer_cmd_t cmd);
        longint rx, ry, px, py, mag, w;
        int lin;
        done = 0;
        if (fin && r < dist_thr && r < near_rng) begin
            near_rng = r;
            near_ang = fold_angle(beam_q);
            found_q  = 1'b1;
        end
        beam_q = beam_q + {{9{ang_step[14]}}, ang_step};
        if (!lst) return;
        rx = longint'(att_gain) <<< 16;
        ry = 0;
        if (found_q && near_rng > 0) begin
            mag = (longint'(rep_gain) * 1000) / near_rng;
            if (mag > 65535) mag = 65535;
            rotate_vec(mag * GAIN16, longint'(near_ang) * 8, px, py);
            rx -= px;
            ry -= py;
        end
        lin = found_q ? int'((longint'(max_lin) * near_rng) / dist_thr) : max_lin;
        w = (heading_of(rx, ry) + 4) >>> 3;
        if (w > max_ang) w = max_ang;
        else if (w < -max_ang) w = -max_ang;
        cmd.lin = lin[15:0];
        cmd.ang = w[15:0];
        cmd.found = found_q;
        done = 1;
        rearm_scan();
    endtask

    // Present one register write until the next clock edge; the caller drops the enable.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ATT_GAIN:  att_gain = val;
            REG_REP_GAIN:  rep_gain = val;
            REG_THRESHOLD: dist_thr = val;
            REG_MAX_LIN:   max_lin = val;
            REG_MAX_ANG:   max_ang = val[14:0];
            REG_ANG_START: begin
                ang_start = val;
                rearm_scan();
            end
            REG_ANG_STEP:  ang_step = val[14:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_settings(input int att, rep, thr, lin, amax, start, step);
        write_reg(REG_ATT_GAIN, att[15:0]);
        write_reg(REG_REP_GAIN, rep[15:0]);
        write_reg(REG_THRESHOLD, thr[15:0]);
        write_reg(REG_MAX_LIN, lin[15:0]);
        write_reg(REG_MAX_ANG, amax[15:0]);
        write_reg(REG_ANG_START, start[15:0]);
        write_reg(REG_ANG_STEP, {1'b0, step[14:0]});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every command has come out and the block has gone quiet.
    task automatic drain();
        while (cmd_q.size() != 0) @(posedge aclk);
        repeat (STALL_BUDGET) @(posedge aclk);
    endtask

    // Present one beam word and hold it until taken; predict at the handshake.
    task automatic send_beam(input logic [15:0] r, input logic fin, input logic lst,
                             input bit typed, input logic [15:0] t_lin, input logic t_found);
        bit done;
        steer_cmd_t cmd;
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        s_tuser  <= fin;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        track_beam(r, fin, lst, done, cmd);
        if (done) begin
            if (typed) begin
                cmd.lin = t_lin;
                cmd.found = t_found;
            end
            cmd_q.insert(cmd_q.size(), cmd);
        end
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // Check each command word against the oldest expectation; stall in bursts.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cmd_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected command word %h/%b", m_tdata, m_tuser);
                end else begin
                    steer_cmd_t e;
                    e = cmd_q.pop_front();
                    if (m_tdata[15:0] !== e.lin || m_tdata[31:16] !== e.ang
                            || m_tuser !== e.found) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("command mismatch: exp lin %h ang %h obs %b, got %h %h %b",
                                     e.lin, e.ang, e.found,
                                     m_tdata[15:0], m_tdata[31:16], m_tuser);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
            end
        end
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

    beam_row_t rows[] = '{
        '{16'd2000,  1'b1, 1'b1, 1, 16'd2048, 1'b0},  // nothing under threshold
        '{16'd0,     1'b1, 1'b1, 1, 16'd0,    1'b1},  // obstacle at zero distance
        '{16'hFFFF,  1'b1, 1'b1, 1, 16'd2048, 1'b0},  // top of range
        '{16'd100,   1'b0, 1'b1, 1, 16'd2048, 1'b0},  // invalid reading ignored
        '{16'd1500,  1'b1, 1'b0, 0, 16'd0,    1'b0},  // exactly at threshold
        '{16'd1499,  1'b1, 1'b0, 0, 16'd0,    1'b0},
        '{16'd1499,  1'b1, 1'b0, 0, 16'd0,    1'b0},  // tie keeps earlier beam
        '{16'd700,   1'b0, 1'b0, 0, 16'd0,    1'b0},
        '{16'd750,   1'b1, 1'b1, 0, 16'd0,    1'b0},
        '{16'd1,     1'b1, 1'b1, 0, 16'd0,    1'b0},  // saturated repulsion
        '{16'd5000,  1'b1, 1'b0, 0, 16'd0,    1'b0},
        '{16'd400,   1'b1, 1'b0, 0, 16'd0,    1'b0},
        '{16'd800,   1'b1, 1'b1, 0, 16'd0,    1'b0}
    };

    initial begin
        int len, thr_hi;
        logic [15:0] r;
        att_gain = 4096; rep_gain = 6144; dist_thr = 1500; max_lin = 2048; max_ang = 8192;
        ang_start = 16'(-25736);
        ang_step = 15'd143;
        rearm_scan();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table at reset settings.
        foreach (rows[i])
            send_beam(rows[i].range_mm, rows[i].finite, rows[i].last,
                      rows[i].typed, rows[i].lin, rows[i].found);
        s_tvalid <= 1'b0;
        drain();

        // Config phases: extremes first, then random settings; no idling in the last.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_settings(65535, 65535, 65535, 65535, 32767, 25736, 8192);
                1: load_settings(0, 0, 0, 0, 0, -25736, -8192);        // zero threshold
                2: load_settings(0, 40000, 3000, 30000, 32767, 0, 0);  // pushes straight back
                3: load_settings(4096, 6144, 1, 2048, 8192, 0, 1);
                default: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                       $urandom_range(1, 65535), $urandom_range(0, 65535),
                                       $urandom_range(0, 32767), $urandom_range(0, 51472) - 25736,
                                       $urandom_range(0, 16384) - 8192);
            endcase
            quiet = (ph == 8);
            for (int n = 0; n < 150; n += len) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                   : $urandom_range(1, 12);
                // Occasionally hold off the next scan until the output side is empty.
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    s_tvalid <= 1'b0;
                    while (cmd_q.size() != 0) @(posedge aclk);
                end
                thr_hi = dist_thr + dist_thr / 4;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 65535);
                    else r = $urandom_range(0, thr_hi > 65535 ? 65535 : thr_hi);
                    send_beam(r, $urandom_range(0, 9) != 0, k == len - 1, 0, '0, 1'b0);
                end
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== vff_obstacle_steering.f =====
design/vos_pkg.sv
design/vos_ctrl.sv
design/vos_dpath.sv
design/vff_obstacle_steering.sv
tb/sv/tb.sv
